/* rtl/sld_pkg.sv */
package sld_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned IndexW    = 9;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned FifoDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_FIRST  = 1'b0,
    CFG_SYNC_SECOND = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_LEN     = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_LEN = 2'd0,
    KIND_PAY = 2'd1,
    KIND_CHK = 2'd2
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    kind_e            kind;
  } q_entry_t;

  typedef struct packed {
    logic             we;
    cfg_reg_e         idx;
    logic [ByteW-1:0] data;
  } cfg_wr_t;

endpackage

/* rtl/sld_cfg_if.sv */
interface sld_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sld_pkg::CfgIdxW-1:0]    index;
  logic [sld_pkg::ByteW-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/sld_byte_if.sv */
interface sld_byte_if;
  logic                      valid;
  logic                      ready;
  logic [sld_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/sld_frame_if.sv */
interface sld_frame_if;
  logic                       valid;
  logic                       ready;
  logic [sld_pkg::ByteW-1:0]  frame_byte;
  logic [sld_pkg::IndexW-1:0] byte_index;
  logic                       last;
  logic                       check_good;

  modport source (output valid, output frame_byte, output byte_index, output last,
                  output check_good, input ready);
  modport sink (input valid, input frame_byte, input byte_index, input last,
                input check_good, output ready);
endinterface

/* rtl/sync_length_checksum_deframer.sv */
// Deframer for a received byte stream: hunts for the two configured sync bytes,
// then passes on the length byte, the payload bytes and the checksum byte, each
// tagged with its position after the header (0 is the length byte). The checksum
// beat has last set and check_good telling whether it equals zero minus the sum
// of the length and payload bytes, modulo 256; the hunt restarts after every
// frame. Sync and hunt bytes produce no output beat. One byte is accepted per
// cycle unless the queue is full; a frame byte goes through the queue, then the
// output register. The parser front end and checksum back end are joined by a
// FifoDepth-entry queue, so the input keeps taking bytes for that many frame
// bytes while the output is stalled. Write sync registers only while idle.
module sync_length_checksum_deframer #(
  parameter int unsigned FifoDepth = sld_pkg::FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sld_cfg_if.sink     cfg_i,
  sld_byte_if.sink    rx_i,
  sld_frame_if.source frame_o
);

  sld_pkg::cfg_wr_t  cfg_wr;
  sld_pkg::q_entry_t push_entry, head_entry;
  logic              q_push, q_pop, q_full, q_empty;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr.we   = cfg_i.valid;
  assign cfg_wr.idx  = sld_pkg::cfg_reg_e'(cfg_i.index);
  assign cfg_wr.data = cfg_i.data;

  sld_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_wr),
    .in_valid_i (rx_i.valid),
    .in_byte_i  (rx_i.rx_byte),
    .in_ready_o (rx_i.ready),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry)
  );

  sld_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (head_entry),
    .empty_o (q_empty)
  );

  sld_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_entry_i    (head_entry),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .out_ready_i  (frame_o.ready),
    .out_valid_o  (frame_o.valid),
    .frame_byte_o (frame_o.frame_byte),
    .byte_index_o (frame_o.byte_index),
    .last_o       (frame_o.last),
    .check_good_o (frame_o.check_good)
  );

`ifndef SYNTH
  // only the checksum beat may report a good check
  a_good_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.valid && !frame_o.last |-> !frame_o.check_good)
    else $error("check_good set on a non-last beat");

  // the length beat never closes a frame
  a_len_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.valid && frame_o.byte_index == '0 |-> !frame_o.last)
    else $error("length beat marked last");

  // a beat taken right after a last beat can only be a new length byte
  a_restart_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_o.valid && frame_o.ready && frame_o.last ##1 frame_o.valid
      |-> frame_o.byte_index == '0)
    else $error("frame did not restart at index zero");

  // input stalls only when the queue holds entries
  a_stall_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> !q_empty)
    else $error("input stalled with empty queue");
`endif

endmodule

/* rtl/sld_front.sv */
module sld_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sld_pkg::cfg_wr_t          cfg_i,
  input  logic                      in_valid_i,
  input  logic [sld_pkg::ByteW-1:0] in_byte_i,
  output logic                      in_ready_o,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output sld_pkg::q_entry_t         q_entry_o
);

  logic [sld_pkg::ByteW-1:0] sync_first_q, sync_second_q;
  sld_pkg::phase_e           phase_q, phase_d;
  logic [sld_pkg::ByteW-1:0] rem_q, rem_d;
  logic                      accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= '0;
      sync_second_q <= '0;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        sld_pkg::CFG_SYNC_FIRST:  sync_first_q  <= cfg_i.data;
        sld_pkg::CFG_SYNC_SECOND: sync_second_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    if (accept) begin
      case (phase_q)
        sld_pkg::PH_HUNT2: begin
          // second sync wins even when it also matches the first
          if (in_byte_i == sync_second_q) phase_d = sld_pkg::PH_LEN;
          else if (in_byte_i == sync_first_q) phase_d = sld_pkg::PH_HUNT2;
          else phase_d = sld_pkg::PH_HUNT1;
        end
        sld_pkg::PH_LEN: begin
          rem_d   = in_byte_i;
          phase_d = (in_byte_i == '0) ? sld_pkg::PH_CHECK : sld_pkg::PH_PAYLOAD;
        end
        sld_pkg::PH_PAYLOAD: begin
          rem_d = rem_q - 1'b1;
          if (rem_q == sld_pkg::ByteW'(1)) phase_d = sld_pkg::PH_CHECK;
        end
        sld_pkg::PH_CHECK: begin
          rem_d   = '0;
          phase_d = sld_pkg::PH_HUNT1;
        end
        default: begin
          phase_d = (in_byte_i == sync_first_q) ? sld_pkg::PH_HUNT2 : sld_pkg::PH_HUNT1;
        end
      endcase
    end
  end

  // classify the beat for the back end
  always_comb begin
    q_push_o       = 1'b0;
    q_entry_o.data = in_byte_i;
    q_entry_o.kind = sld_pkg::KIND_LEN;
    case (phase_q)
      sld_pkg::PH_LEN: begin
        q_push_o = accept;
      end
      sld_pkg::PH_PAYLOAD: begin
        q_push_o       = accept;
        q_entry_o.kind = sld_pkg::KIND_PAY;
      end
      sld_pkg::PH_CHECK: begin
        q_push_o       = accept;
        q_entry_o.kind = sld_pkg::KIND_CHK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sld_pkg::PH_HUNT1;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
    end
  end

endmodule

/* rtl/sld_fifo.sv */
module sld_fifo #(
  parameter int unsigned Depth = sld_pkg::FifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sld_pkg::q_entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output sld_pkg::q_entry_t entry_o,
  output logic              empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  sld_pkg::q_entry_t mem_q [Depth];
  logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

/* rtl/sld_back.sv */
module sld_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sld_pkg::q_entry_t          q_entry_i,
  input  logic                       q_empty_i,
  output logic                       q_pop_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [sld_pkg::ByteW-1:0]  frame_byte_o,
  output logic [sld_pkg::IndexW-1:0] byte_index_o,
  output logic                       last_o,
  output logic                       check_good_o
);

  logic                       out_valid_q;
  logic [sld_pkg::ByteW-1:0]  check_q, check_d;
  logic [sld_pkg::IndexW-1:0] pos_q, pos_d;
  logic [sld_pkg::IndexW-1:0] idx_d;
  logic                       last_d, good_d;

  // output register frees up when empty or being taken this cycle
  assign q_pop_o     = (!out_valid_q || out_ready_i) && !q_empty_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    check_d = check_q;
    pos_d   = pos_q;
    idx_d   = pos_q;
    last_d  = 1'b0;
    good_d  = 1'b0;
    case (q_entry_i.kind)
      sld_pkg::KIND_LEN: begin
        idx_d   = '0;
        check_d = '0 - q_entry_i.data;
        pos_d   = sld_pkg::IndexW'(1);
      end
      sld_pkg::KIND_PAY: begin
        check_d = check_q - q_entry_i.data;
        pos_d   = pos_q + 1'b1;
      end
      sld_pkg::KIND_CHK: begin
        last_d  = 1'b1;
        good_d  = (q_entry_i.data == check_q);
        check_d = '0;
        pos_d   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      check_q     <= '0;
      pos_q       <= '0;
    end else begin
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
        check_q     <= check_d;
        pos_q       <= pos_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      frame_byte_o <= q_entry_i.data;
      byte_index_o <= idx_d;
      last_o       <= last_d;
      check_good_o <= good_d;
    end
  end

endmodule
